/* hw/rtl/wrmf_pkg.sv */
package wrmf_pkg;

    localparam int MAX_WINDOW    = 7;
    localparam int SAMPLE_BITS   = 16;
    localparam int WEIGHT_BITS   = 16;
    localparam int PROD_BITS     = SAMPLE_BITS + WEIGHT_BITS;
    localparam int HW_BITS       = 2;
    localparam int HW_MAX        = (MAX_WINDOW - 1) / 2;
    localparam int CNT_BITS      = $clog2(MAX_WINDOW + 1);
    localparam int POS_BITS      = $clog2(MAX_WINDOW);
    localparam int OFF_BITS      = POS_BITS + 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_WIDTH = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WEIGHT_0   = 3'd1;

    localparam logic [HW_BITS-1:0]     HW_RESET     = 2'd1;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 16'd4096;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [WEIGHT_BITS-1:0] weight_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;

    typedef sample_t [MAX_WINDOW-1:0] window_t;
    typedef weight_t [MAX_WINDOW-1:0] weight_set_t;

    typedef struct packed {
        logic [HW_BITS-1:0]  d;
        logic                last;
        logic [CNT_BITS-1:0] cnt;
    } job_t;

    typedef struct packed {
        window_t                   vals;
        prod_t [MAX_WINDOW-1:0]    prods;
        logic [HW_BITS-1:0]        hw;
        logic                      is_final;
    } lane_set_t;

endpackage

/* hw/rtl/wrmf_in_if.sv */
interface wrmf_in_if;
    logic              valid;
    logic              ready;
    wrmf_pkg::sample_t sample_in;
    logic              end_of_signal;

    modport source (output valid, output sample_in, output end_of_signal, input ready);
    modport sink (input valid, input sample_in, input end_of_signal, output ready);
endinterface

/* hw/rtl/wrmf_out_if.sv */
interface wrmf_out_if;
    logic              valid;
    logic              ready;
    wrmf_pkg::sample_t sample_out;
    logic              final_out;

    modport source (output valid, output sample_out, output final_out, input ready);
    modport sink (input valid, input sample_out, input final_out, output ready);
endinterface

/* hw/rtl/wrmf_window.sv */
module wrmf_window (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  wrmf_pkg::sample_t              in_sample,
    input  logic                           in_last,
    output logic                           in_ready,
    input  logic [wrmf_pkg::HW_BITS-1:0]   hw,
    input  logic                           issue_ready,
    output logic                           job_valid,
    output wrmf_pkg::job_t                 job,
    output wrmf_pkg::window_t              window
);
    import wrmf_pkg::*;

    window_t             window_reg, window_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                job_valid_reg, job_valid_next;
    job_t                job_reg, job_next;

    logic                issue;
    logic                accept;
    logic                job_done;
    logic [CNT_BITS-1:0] count_inc;
    logic [CNT_BITS-1:0] top;

    // a plain job issues once, a flush job steps down to position zero
    assign job_done  = !job_reg.last || (job_reg.d == '0);
    assign issue     = job_valid_reg && issue_ready;
    assign in_ready  = !job_valid_reg || (issue_ready && job_done);
    assign accept    = in_valid && in_ready;
    assign count_inc = (cnt_reg == CNT_BITS'(MAX_WINDOW)) ? cnt_reg : cnt_reg + 1'b1;
    assign top       = count_inc - 1'b1;

    always_comb
    begin
        window_next    = window_reg;
        cnt_next       = cnt_reg;
        job_valid_next = job_valid_reg;
        job_next       = job_reg;
        if (issue)
        begin
            if (job_done)
            begin
                job_valid_next = 1'b0;
            end
            else
            begin
                job_next.d = job_reg.d - 1'b1;
            end
        end
        if (accept)
        begin
            window_next[0] = in_sample;
            for (int i = 1; i < MAX_WINDOW; i++)
            begin
                window_next[i] = window_reg[i-1];
            end
            job_next.cnt = count_inc;
            if (in_last)
            begin
                cnt_next       = '0;
                job_valid_next = 1'b1;
                job_next.last  = 1'b1;
                job_next.d     = (top > CNT_BITS'(hw)) ? hw : top[HW_BITS-1:0];
            end
            else
            begin
                cnt_next      = count_inc;
                job_next.last = 1'b0;
                job_next.d    = hw;
                if (count_inc > CNT_BITS'(hw))
                begin
                    job_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            cnt_reg       <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            cnt_reg       <= cnt_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;
    assign window    = window_reg;

    // window count saturates
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(MAX_WINDOW))
        else $error("window count above window depth");

    // a job never reaches behind its own clamp range
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (job_reg.d <= hw) && (job_reg.cnt != '0))
        else $error("job position out of range");

    // an end-of-signal transfer restarts the count
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> cnt_reg == '0)
        else $error("count not cleared after end of signal");

endmodule

/* hw/rtl/wrmf_gather_mult.sv */
module wrmf_gather_mult (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_valid,
    input  wrmf_pkg::job_t                 job,
    input  wrmf_pkg::window_t              window,
    input  logic [wrmf_pkg::HW_BITS-1:0]   hw,
    input  wrmf_pkg::weight_set_t          weights,
    output logic                           issue_ready,
    input  logic                           s2_ready,
    output logic                           s1_valid,
    output wrmf_pkg::lane_set_t            s1
);
    import wrmf_pkg::*;

    logic                s1_valid_reg;
    lane_set_t           s1_reg, s1_next;
    logic signed [OFF_BITS-1:0] off [MAX_WINDOW];
    logic [POS_BITS-1:0]        pos [MAX_WINDOW];
    logic [CNT_BITS-1:0]        hi;

    assign issue_ready = !s1_valid_reg || s2_ready;
    assign hi          = job.cnt - 1'b1;

    // clamp each tap to the samples present in this signal
    always_comb
    begin
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            off[j] = OFF_BITS'(job.d) + OFF_BITS'(hw) - OFF_BITS'(j);
            if (off[j] < 0)
            begin
                pos[j] = '0;
            end
            else if (off[j] > $signed({1'b0, OFF_BITS'(hi)}))
            begin
                pos[j] = hi[POS_BITS-1:0];
            end
            else
            begin
                pos[j] = off[j][POS_BITS-1:0];
            end
            s1_next.vals[j]  = window[pos[j]];
            s1_next.prods[j] = prod_t'(window[pos[j]]) * prod_t'(weights[j]);
        end
        s1_next.hw       = hw;
        s1_next.is_final = job.last && (job.d == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (issue_ready)
        begin
            s1_valid_reg <= job_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_ready)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule

/* hw/rtl/wrmf_rank_select.sv */
module wrmf_rank_select (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s1_valid,
    input  wrmf_pkg::lane_set_t s1,
    output logic                s2_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output wrmf_pkg::sample_t   sample_out,
    output logic                final_out
);
    import wrmf_pkg::*;

    logic                out_valid_reg;
    sample_t             sample_reg, sample_next;
    logic                final_reg;
    logic [POS_BITS-1:0] rank [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] used;
    logic [MAX_WINDOW-1:0] hit;

    assign s2_ready = !out_valid_reg || out_ready;

    // rank ascending, ties kept in window order
    always_comb
    begin
        sample_next = '0;
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            used[j] = POS_BITS'(j) <= {s1.hw, 1'b0};
        end
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            rank[j] = '0;
            for (int k = 0; k < MAX_WINDOW; k++)
            begin
                if (used[k] && ((s1.prods[k] < s1.prods[j]) ||
                                (s1.prods[k] == s1.prods[j] && k < j)))
                begin
                    rank[j] = rank[j] + 1'b1;
                end
            end
            hit[j] = used[j] && (rank[j] == POS_BITS'(s1.hw));
        end
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            if (hit[j])
            begin
                sample_next = s1.vals[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            sample_reg <= sample_next;
            final_reg  <= s1.is_final;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_reg;
    assign final_out  = final_reg;

    // exactly one tap holds the middle rank
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid |-> $countones(hit) == 1)
        else $error("middle rank not unique");

    // a lane set moving forward lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && s2_ready |=> out_valid_reg)
        else $error("result lost on the way to the output register");

endmodule

/* hw/rtl/weighted_rank_median_filter_core.sv */
// Weighted rank median filter: takes one signed sample per cycle unless held off by output
// back-pressure or a flush and, for every sample, returns the window sample whose weighted
// product holds the middle rank over 2*half_width+1 taps with the signal edges replicated.
// Output m leaves once sample m+half_width has been transferred; an end_of_signal sample
// flushes up to half_width+1 results, one per cycle unless stalled, and holds off the next
// sample until the last of them issues. The completing transfer loads the job register, then
// the product and output registers follow, with the seven tap multipliers side by side
// between the job and product registers. Write configuration only while idle.
module weighted_rank_median_filter_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    wrmf_in_if.sink                              samples,
    wrmf_out_if.source                           results,
    input  logic                                 cfg_we,
    input  logic [wrmf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [wrmf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import wrmf_pkg::*;

    logic [HW_BITS-1:0]      hw_reg;
    weight_set_t             weight_reg;
    logic [HW_BITS-1:0]      hw_eff;
    logic [CFG_IDX_BITS-1:0] weight_sel;

    logic      job_valid;
    job_t      job;
    window_t   window;
    logic      issue_ready;
    logic      s2_ready;
    logic      s1_valid;
    lane_set_t s1;

    assign weight_sel = cfg_index - CFG_WEIGHT_0;
    assign hw_eff     = (hw_reg > HW_BITS'(HW_MAX)) ? HW_BITS'(HW_MAX) : hw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg <= HW_RESET;
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                weight_reg[i] <= WEIGHT_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HALF_WIDTH:
                begin
                    hw_reg <= cfg_data[HW_BITS-1:0];
                end
                default:
                begin
                    weight_reg[weight_sel[POS_BITS-1:0]] <= cfg_data[WEIGHT_BITS-1:0];
                end
            endcase
        end
    end

    wrmf_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (samples.valid),
        .in_sample   (samples.sample_in),
        .in_last     (samples.end_of_signal),
        .in_ready    (samples.ready),
        .hw          (hw_eff),
        .issue_ready (issue_ready),
        .job_valid   (job_valid),
        .job         (job),
        .window      (window)
    );

    wrmf_gather_mult u_gather_mult (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job         (job),
        .window      (window),
        .hw          (hw_eff),
        .weights     (weight_reg),
        .issue_ready (issue_ready),
        .s2_ready    (s2_ready),
        .s1_valid    (s1_valid),
        .s1          (s1)
    );

    wrmf_rank_select u_rank_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid),
        .s1         (s1),
        .s2_ready   (s2_ready),
        .out_valid  (results.valid),
        .out_ready  (results.ready),
        .sample_out (results.sample_out),
        .final_out  (results.final_out)
    );

endmodule
